// ----- hw/rtl/ideu_pkg.sv -----
// ----------------------------------------------------------------------------
// ideu_pkg
// Shared types and constants for the inverse-distance element average unit.
// ----------------------------------------------------------------------------
package ideu_pkg;

  // Shared divider: unsigned dividend and divisor widths
  localparam int DIV_NW   = 64;
  localparam int DIV_DW   = 35;
  localparam int DIV_CNTW = 6;

  // Square root: radicand is the sum of three 33-bit squares
  localparam int RAD_W    = 66;
  localparam int ROOT_W   = 33;
  localparam int SQ_CNTW  = 6;

  // Weight fraction bits (Q1.24) and unit distance (1.0 in Q16.16)
  localparam int WFRAC    = 24;
  localparam int UNIT_DIST = 65536;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SUM,
    OP_CDIV_START,
    OP_CENT_WR,
    OP_DIFF,
    OP_SQ0,
    OP_SQ1,
    OP_SQ2,
    OP_SQ3,
    OP_SQRT_START,
    OP_DIST_WR,
    OP_WONE,
    OP_WDIV_START,
    OP_WQUO,
    OP_WMUL,
    OP_WACC,
    OP_FDIV_START,
    OP_RES
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    logic       first;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic dist_zero;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/inverse_distance_element_average_unit.sv -----
// Processing: an n-node cell, after its last node is taken, uses the shared divider
// for 3 centroid, up to n weight and 1 final divides, and the square root once per
// node, before its result is shown.
// Throughput: one cell at a time; the result register frees the input early.
// Reset (rst, synchronous): node count, overflow flag and control return to idle.
// ----------------------------------------------------------------------------
// inverse_distance_element_average_unit
// Inverse-distance weighted average of the nodal values of one mesh cell.
// ----------------------------------------------------------------------------
module inverse_distance_element_average_unit #(
  parameter int MAX_NODES = 16
) (
  input  logic               clk,
  input  logic               rst,
  // node channel: one transaction per node
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] x_coord,
  input  logic signed [31:0] y_coord,
  input  logic signed [31:0] z_coord,
  input  logic signed [31:0] node_value,
  input  logic               last_node,
  // result channel: one transaction per cell
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] element_value,
  output logic [4:0]         node_total,
  output logic               overflow
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  // controller commands, datapath status
  ideu_pkg::cmd_t    cmd;
  ideu_pkg::status_t sts;
  logic [AW-1:0]     addr;
  logic [CW-1:0]     count;

  // Controller: input handshake and the per-node loops
  ideu_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_node (last_node),
    .sts       (sts),
    .count     (count),
    .cmd       (cmd),
    .addr      (addr)
  );

  // Datapath: node buffer, arithmetic and the result register
  ideu_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .addr          (addr),
    .sts           (sts),
    .count         (count),
    .x_coord       (x_coord),
    .y_coord       (y_coord),
    .z_coord       (z_coord),
    .node_value    (node_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .element_value (element_value),
    .node_total    (node_total),
    .overflow      (overflow)
  );

endmodule

// ----- hw/rtl/ideu_divider.sv -----
// ----------------------------------------------------------------------------
// ideu_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ideu_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ideu_pkg::DIV_NW-1:0]    num,
  input  logic [ideu_pkg::DIV_DW-1:0]    den,
  output logic [ideu_pkg::DIV_NW-1:0]    quo,
  output logic                           rem_nz,
  output logic                           done
);

  logic                          busy;
  logic [ideu_pkg::DIV_CNTW-1:0] cnt;
  logic [ideu_pkg::DIV_DW-1:0]   rem;
  logic [ideu_pkg::DIV_DW-1:0]   den_r;
  logic [ideu_pkg::DIV_DW:0]     rem2;
  logic [ideu_pkg::DIV_DW:0]     diff;
  logic                          ge;

  assign rem2   = {rem, quo[ideu_pkg::DIV_NW-1]};
  assign ge     = rem2 >= {1'b0, den_r};
  assign diff   = rem2 - {1'b0, den_r};
  assign rem_nz = rem != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ideu_pkg::DIV_CNTW'(ideu_pkg::DIV_NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[ideu_pkg::DIV_DW-1:0] : rem2[ideu_pkg::DIV_DW-1:0];
      quo <= {quo[ideu_pkg::DIV_NW-2:0], ge};
    end
  end

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
`endif

endmodule

// ----- hw/rtl/ideu_sqrt.sv -----
// ----------------------------------------------------------------------------
// ideu_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module ideu_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ideu_pkg::RAD_W-1:0]   rad,
  output logic [ideu_pkg::ROOT_W-1:0]  root,
  output logic                         done
);

  logic                          busy;
  logic [ideu_pkg::SQ_CNTW-1:0]  cnt;
  logic [ideu_pkg::RAD_W-1:0]    rad_r;
  logic [ideu_pkg::ROOT_W+1:0]   rem;
  logic [ideu_pkg::ROOT_W+3:0]   rem2;
  logic [ideu_pkg::ROOT_W+3:0]   trial;
  logic [ideu_pkg::ROOT_W+3:0]   diff;
  logic                          ge;

  assign rem2  = {rem, rad_r[ideu_pkg::RAD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = rem2 >= trial;
  assign diff  = rem2 - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == ideu_pkg::SQ_CNTW'(ideu_pkg::ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= rad;
      rem   <= '0;
      root  <= '0;
    end else if (busy) begin
      rad_r <= {rad_r[ideu_pkg::RAD_W-3:0], 2'b00};
      rem   <= ge ? diff[ideu_pkg::ROOT_W+1:0] : rem2[ideu_pkg::ROOT_W+1:0];
      root  <= {root[ideu_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule

// ----- hw/rtl/ideu_datapath.sv -----
// ----------------------------------------------------------------------------
// ideu_datapath
// Node buffer, accumulators, multipliers and the divide/sqrt units.
// ----------------------------------------------------------------------------
module ideu_datapath #(
  parameter int MAX_NODES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ideu_pkg::cmd_t                        cmd,
  input  logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] addr,
  output ideu_pkg::status_t                     sts,
  output logic [$clog2(MAX_NODES + 1)-1:0]      count,
  input  logic signed [31:0]                    x_coord,
  input  logic signed [31:0]                    y_coord,
  input  logic signed [31:0]                    z_coord,
  input  logic signed [31:0]                    node_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [31:0]                    element_value,
  output logic [4:0]                            node_total,
  output logic                                  overflow
);

  localparam int AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int SW  = 32 + CW;
  localparam int WW  = ideu_pkg::WFRAC + 1;
  localparam int WSW = WW + CW;
  localparam int DW  = ideu_pkg::ROOT_W;
  localparam logic [CW-1:0] MAXC = CW'(MAX_NODES);

  // node buffer and distance buffer
  logic [127:0]  node_mem [MAX_NODES];
  logic [127:0]  node_q;
  logic [DW-1:0] dist_mem [MAX_NODES];
  logic [DW-1:0] dist_q;

  logic [CW-1:0] node_count;
  logic          overflow_seen;

  logic signed [SW-1:0] sum_x, sum_y, sum_z, sel_sum;
  logic [SW-1:0]        abs_sum;
  logic signed [31:0]   cx, cy, cz;
  logic signed [31:0]   nx, ny, nz, nval;
  logic signed [32:0]   dx, dy, dz;
  logic [32:0]          ax, ay, az, sq_sel;
  logic [65:0]          prod, sq;
  logic [DW-1:0]        min_d, m_cand;
  logic [WW-1:0]        wgt;
  logic signed [57:0]   wprod;
  logic signed [63:0]   acc;
  logic [63:0]          acc_mag;
  logic [WSW-1:0]       wsum;
  logic [63:0]          cent_q;
  logic [31:0]          res_v;

  logic [ideu_pkg::DIV_NW-1:0] div_num, div_quo;
  logic [ideu_pkg::DIV_DW-1:0] div_den;
  logic                        div_start, div_rnz, div_done;
  logic                        sqrt_start, sqrt_done;
  logic [DW-1:0]               root;

  assign nx   = node_q[127:96];
  assign ny   = node_q[95:64];
  assign nz   = node_q[63:32];
  assign nval = node_q[31:0];

  assign dx = {nx[31], nx} - {cx[31], cx};
  assign dy = {ny[31], ny} - {cy[31], cy};
  assign dz = {nz[31], nz} - {cz[31], cz};

  always_comb begin
    case (cmd.axis)
      2'd0:    sel_sum = sum_x;
      2'd1:    sel_sum = sum_y;
      default: sel_sum = sum_z;
    endcase
  end
  assign abs_sum = sel_sum[SW-1] ? SW'(-sel_sum) : SW'(sel_sum);
  assign acc_mag = acc[63] ? 64'(-acc) : 64'(acc);
  assign cent_q  = sel_sum[SW-1] ? (64'd0 - (div_quo + 64'(div_rnz))) : div_quo;
  assign m_cand  = (root == '0) ? DW'(ideu_pkg::UNIT_DIST) : root;

  always_comb begin
    case (cmd.op)
      ideu_pkg::OP_SQ1: sq_sel = ay;
      ideu_pkg::OP_SQ2: sq_sel = az;
      default:          sq_sel = ax;
    endcase
  end

  // shared divider operand select
  assign div_start = (cmd.op == ideu_pkg::OP_CDIV_START) ||
                     (cmd.op == ideu_pkg::OP_WDIV_START) ||
                     (cmd.op == ideu_pkg::OP_FDIV_START);
  always_comb begin
    div_num = '0;
    div_den = '0;
    case (cmd.op)
      ideu_pkg::OP_CDIV_START: begin
        div_num = ideu_pkg::DIV_NW'(abs_sum);
        div_den = ideu_pkg::DIV_DW'(node_count);
      end
      ideu_pkg::OP_WDIV_START: begin
        div_num = ideu_pkg::DIV_NW'(min_d) << ideu_pkg::WFRAC;
        div_den = ideu_pkg::DIV_DW'(dist_q);
      end
      ideu_pkg::OP_FDIV_START: begin
        div_num = acc_mag + ideu_pkg::DIV_NW'(wsum >> 1);
        div_den = ideu_pkg::DIV_DW'(wsum);
      end
      default: ;
    endcase
  end

  // rounded quotient, signed and saturated
  always_comb begin
    if (wsum == '0) begin
      res_v = '0;
    end else if (acc[63]) begin
      res_v = (div_quo >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-div_quo[31:0]);
    end else begin
      res_v = (div_quo >= 64'h8000_0000) ? 32'h7FFF_FFFF : div_quo[31:0];
    end
  end

  assign sqrt_start = cmd.op == ideu_pkg::OP_SQRT_START;

  ideu_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .quo    (div_quo),
    .rem_nz (div_rnz),
    .done   (div_done)
  );

  ideu_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (sq),
    .root  (root),
    .done  (sqrt_done)
  );

  // memories
  always_ff @(posedge clk) begin
    if (cmd.op == ideu_pkg::OP_LOAD && node_count < MAXC) begin
      node_mem[node_count[AW-1:0]] <= {x_coord, y_coord, z_coord, node_value};
    end
    node_q <= node_mem[addr];
    if (cmd.op == ideu_pkg::OP_DIST_WR) begin
      dist_mem[addr] <= root;
    end
    dist_q <= dist_mem[addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count    <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.op == ideu_pkg::OP_LOAD) begin
        if (node_count < MAXC) begin
          node_count <= node_count + 1'b1;
        end else begin
          overflow_seen <= 1'b1;
        end
      end
      if (cmd.op == ideu_pkg::OP_RES) begin
        out_valid     <= 1'b1;
        node_count    <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      ideu_pkg::OP_LOAD: begin
        sum_x <= '0;
        sum_y <= '0;
        sum_z <= '0;
        acc   <= '0;
        wsum  <= '0;
      end
      ideu_pkg::OP_SUM: begin
        sum_x <= sum_x + SW'(nx);
        sum_y <= sum_y + SW'(ny);
        sum_z <= sum_z + SW'(nz);
      end
      ideu_pkg::OP_CENT_WR: begin
        case (cmd.axis)
          2'd0:    cx <= cent_q[31:0];
          2'd1:    cy <= cent_q[31:0];
          default: cz <= cent_q[31:0];
        endcase
      end
      ideu_pkg::OP_DIFF: begin
        ax <= dx[32] ? 33'(-dx) : 33'(dx);
        ay <= dy[32] ? 33'(-dy) : 33'(dy);
        az <= dz[32] ? 33'(-dz) : 33'(dz);
      end
      ideu_pkg::OP_SQ0: prod <= sq_sel * sq_sel;
      ideu_pkg::OP_SQ1: begin
        sq   <= prod;
        prod <= sq_sel * sq_sel;
      end
      ideu_pkg::OP_SQ2: begin
        sq   <= sq + prod;
        prod <= sq_sel * sq_sel;
      end
      ideu_pkg::OP_SQ3: sq <= sq + prod;
      ideu_pkg::OP_DIST_WR: begin
        if (cmd.first || m_cand < min_d) begin
          min_d <= m_cand;
        end
      end
      ideu_pkg::OP_WONE: wgt <= WW'(1) << ideu_pkg::WFRAC;
      ideu_pkg::OP_WQUO: wgt <= div_quo[WW-1:0];
      ideu_pkg::OP_WMUL: wprod <= $signed({1'b0, wgt}) * nval;
      ideu_pkg::OP_WACC: begin
        acc  <= acc + 64'(wprod);
        wsum <= wsum + WSW'(wgt);
      end
      ideu_pkg::OP_RES: begin
        element_value <= res_v;
        node_total    <= 5'(node_count);
        overflow      <= overflow_seen;
      end
      default: ;
    endcase
  end

  assign count         = node_count;
  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.dist_zero = dist_q == '0;
  assign sts.out_free  = !out_valid || !out_stall;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) node_count <= MAXC)
    else $error("node count beyond buffer depth");
  a_res_shown: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == ideu_pkg::OP_RES) |=> out_valid)
    else $error("result load did not raise out_valid");
`endif

endmodule

// ----- hw/rtl/ideu_ctrl.sv -----
// ----------------------------------------------------------------------------
// ideu_ctrl
// Sequencer: node loop over sum, centroid, distance, weight and final divide.
// ----------------------------------------------------------------------------
module ideu_ctrl #(
  parameter int MAX_NODES = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  last_node,
  input  ideu_pkg::status_t                     sts,
  input  logic [$clog2(MAX_NODES + 1)-1:0]      count,
  output ideu_pkg::cmd_t                        cmd,
  output logic [((MAX_NODES > 1) ? $clog2(MAX_NODES) : 1)-1:0] addr
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SUM  = 7'b0000010,
    S_CDIV = 7'b0000100,
    S_DIST = 7'b0001000,
    S_WGT  = 7'b0010000,
    S_FDIV = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t        state, state_next;
  logic [2:0]    phase, phase_next;
  logic [CW-1:0] j, j_next;
  logic [1:0]    axis, axis_next;
  logic          last_j;

  assign last_j   = (j + 1'b1) == count;
  assign addr     = j[AW-1:0];
  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    j_next     = j;
    axis_next  = axis;
    cmd.op     = ideu_pkg::OP_NONE;
    cmd.axis   = axis;
    cmd.first  = j == '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = ideu_pkg::OP_LOAD;
          if (last_node) begin
            state_next = S_SUM;
            phase_next = '0;
            j_next     = '0;
          end
        end
      end
      S_SUM: begin
        if (phase == 3'd0) begin
          phase_next = 3'd1;
        end else begin
          cmd.op     = ideu_pkg::OP_SUM;
          phase_next = 3'd0;
          if (last_j) begin
            state_next = S_CDIV;
            axis_next  = '0;
          end else begin
            j_next = j + 1'b1;
          end
        end
      end
      S_CDIV: begin
        if (phase == 3'd0) begin
          cmd.op     = ideu_pkg::OP_CDIV_START;
          phase_next = 3'd1;
        end else if (sts.div_done) begin
          cmd.op     = ideu_pkg::OP_CENT_WR;
          phase_next = 3'd0;
          if (axis == 2'd2) begin
            state_next = S_DIST;
            j_next     = '0;
          end else begin
            axis_next = axis + 1'b1;
          end
        end
      end
      S_DIST: begin
        phase_next = phase + 1'b1;
        case (phase)
          3'd1: cmd.op = ideu_pkg::OP_DIFF;
          3'd2: cmd.op = ideu_pkg::OP_SQ0;
          3'd3: cmd.op = ideu_pkg::OP_SQ1;
          3'd4: cmd.op = ideu_pkg::OP_SQ2;
          3'd5: cmd.op = ideu_pkg::OP_SQ3;
          3'd6: cmd.op = ideu_pkg::OP_SQRT_START;
          3'd7: begin
            phase_next = phase;
            if (sts.sqrt_done) begin
              cmd.op     = ideu_pkg::OP_DIST_WR;
              phase_next = 3'd0;
              if (last_j) begin
                state_next = S_WGT;
                j_next     = '0;
              end else begin
                j_next = j + 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      S_WGT: begin
        case (phase)
          3'd0: phase_next = 3'd1;
          3'd1: begin
            if (sts.dist_zero) begin
              cmd.op     = ideu_pkg::OP_WONE;
              phase_next = 3'd3;
            end else begin
              cmd.op     = ideu_pkg::OP_WDIV_START;
              phase_next = 3'd2;
            end
          end
          3'd2: begin
            if (sts.div_done) begin
              cmd.op     = ideu_pkg::OP_WQUO;
              phase_next = 3'd3;
            end
          end
          3'd3: begin
            cmd.op     = ideu_pkg::OP_WMUL;
            phase_next = 3'd4;
          end
          default: begin
            cmd.op     = ideu_pkg::OP_WACC;
            phase_next = 3'd0;
            if (last_j) begin
              state_next = S_FDIV;
            end else begin
              j_next = j + 1'b1;
            end
          end
        endcase
      end
      S_FDIV: begin
        if (phase == 3'd0) begin
          cmd.op     = ideu_pkg::OP_FDIV_START;
          phase_next = 3'd1;
        end else if (sts.div_done) begin
          state_next = S_EMIT;
          phase_next = 3'd0;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.op     = ideu_pkg::OP_RES;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= '0;
      j     <= '0;
      axis  <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      j     <= j_next;
      axis  <= axis_next;
    end
  end

`ifndef SYNTHESIS
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && last_node) |=> (state == S_SUM))
    else $error("last node did not start cell processing");
`endif

endmodule
